// File: rtl/tspc_pkg.sv
package tspc_pkg;

    // Step table geometry
    localparam int MAX_STEPS   = 4;
    localparam int STEP_REGS   = 4;
    localparam int STEP_SEL_W  = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;
    localparam int STEP_IDX_W  = 3;

    // Field widths
    localparam int TEMP_W      = 13;
    localparam int TIME_W      = 32;
    localparam int WORD_W      = TEMP_W + TIME_W;
    localparam int FUNC_W      = 2;
    localparam int PHASE_W     = 3;
    localparam int CFG_IDX_W   = 3;

    // Stream word layout
    localparam int IN_DATA_W   = 48;
    localparam int OUT_DATA_W  = 16;
    localparam int OUT_USED_W  = 3 + STEP_IDX_W + PHASE_W;

    // Holding band width in 1/16 degree
    localparam logic signed [TEMP_W:0] HYST = 14'sd16;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_STEP_COUNT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_WORD0 = 3'd1;

    typedef enum logic [FUNC_W-1:0] {
        FN_SAMPLE = 2'd0,
        FN_START  = 2'd1,
        FN_STOP   = 2'd2,
        FN_NONE   = 2'd3
    } func_t;

    typedef enum logic [PHASE_W-1:0] {
        PH_OFF       = 3'd0,
        PH_STARTING  = 3'd1,
        PH_STOPPING  = 3'd2,
        PH_PREPARING = 3'd3,
        PH_HOLDING   = 3'd4
    } phase_t;

endpackage

// File: rtl/temperature_step_profile_controller.sv
// Temperature step profile controller. Runs a list of up to four programmed
// steps (target temperature, hold time in ms) and drives a heater flag. Each
// input word is a sample tick, a start, a stop or a no-op (tuser); a
// sample carries the measured temperature in signed 1/16 degree and a wrapping
// millisecond timestamp. Every accepted word yields exactly one status word:
// heater drive, running, step valid, current step and phase, as they stand
// after that word. A start is honored only while off; the next sample selects
// step 0. While preparing, the heater runs until the sample reaches the
// target, then the hold timer starts from that sample's timestamp. While
// holding, the heater follows a one-degree band below the target; once the
// elapsed time (modulo 2^32) exceeds the hold time the block advances, or
// stops after the last step. A stop turns the heater off at once and the
// next sample turns the block off. Throughput is one word per clock while the
// output is not stalled: the whole decision is combinational logic ahead of
// the status register, so tvalid on the output rises in the cycle after acceptance,
// and s_axis_tready stays high as long as the output register is empty or
// being drained. Write configuration only while the block is idle.
module temperature_step_profile_controller
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    // Step program writes
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [tspc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [tspc_pkg::WORD_W-1:0]          cfg_data,
    // Input words
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [tspc_pkg::IN_DATA_W-1:0]       s_axis_tdata,  // sample_temp, timestamp_ms
    input  logic [tspc_pkg::FUNC_W-1:0]          s_axis_tuser,  // func
    // Status words
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    output logic [tspc_pkg::OUT_DATA_W-1:0]      m_axis_tdata   // heater_on, running,
                                                                // step_valid, current_step,
                                                                // phase
);
    import tspc_pkg::*;

    // Program registers
    logic [STEP_IDX_W-1:0]  step_count_reg;
    logic [WORD_W-1:0]      step_word_reg [MAX_STEPS];

    // Controller state
    phase_t                 phase_reg, phase_next;
    logic [STEP_IDX_W-1:0]  step_index_reg, step_index_next;
    logic                   index_valid_reg, index_valid_next;
    logic [TIME_W-1:0]      hold_start_reg, hold_start_next;
    logic                   heater_reg, heater_next;

    // Output register
    logic                   m_valid_reg;
    logic [OUT_DATA_W-1:0]  m_data_reg;

    logic                   s_fire;
    logic                   cfg_fire;
    func_t                  func;
    logic signed [TEMP_W-1:0] sample_temp;
    logic [TIME_W-1:0]      timestamp_ms;

    logic [STEP_IDX_W-1:0]  active_count;
    logic [WORD_W-1:0]      cur_word;
    logic signed [TEMP_W-1:0] target;
    logic [TIME_W-1:0]      hold_ms;
    logic [TIME_W-1:0]      elapsed;
    logic signed [TEMP_W:0] band_low;
    logic signed [TEMP_W:0] temp_ext;
    logic [STEP_IDX_W-1:0]  step_inc;
    logic [STEP_IDX_W-1:0]  cur_step_out;

    assign cfg_ready     = 1'b1;
    assign cfg_fire      = cfg_valid && cfg_ready;
    assign s_axis_tready = !m_valid_reg || m_axis_tready;
    assign s_fire        = s_axis_tvalid && s_axis_tready;

    assign func          = func_t'(s_axis_tuser);
    assign sample_temp   = s_axis_tdata[TEMP_W-1:0];
    assign timestamp_ms  = s_axis_tdata[TEMP_W +: TIME_W];

    // Count in use is capped at the table depth
    assign active_count  = (step_count_reg > STEP_IDX_W'(MAX_STEPS))
                         ? STEP_IDX_W'(MAX_STEPS) : step_count_reg;

    assign cur_word      = step_word_reg[step_index_reg[STEP_SEL_W-1:0]];
    assign target        = cur_word[TIME_W +: TEMP_W];
    assign hold_ms       = cur_word[TIME_W-1:0];
    assign elapsed       = timestamp_ms - hold_start_reg;
    assign temp_ext      = {sample_temp[TEMP_W-1], sample_temp};
    assign band_low      = {target[TEMP_W-1], target} - HYST;
    assign step_inc      = step_index_reg + 1'b1;

    // Program writes; word registers beyond the table depth drop
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_count_reg <= '0;
            for (int k = 0; k < MAX_STEPS; k++)
            begin
                step_word_reg[k] <= '0;
            end
        end
        else if (cfg_fire)
        begin
            if (cfg_index == REG_STEP_COUNT)
            begin
                step_count_reg <= cfg_data[STEP_IDX_W-1:0];
            end
            for (int k = 0; k < MAX_STEPS; k++)
            begin
                if (k < STEP_REGS && cfg_index == REG_STEP_WORD0 + CFG_IDX_W'(k))
                begin
                    step_word_reg[k] <= cfg_data;
                end
            end
        end
    end

    // Next state for one input word
    always_comb
    begin
        phase_next       = phase_reg;
        step_index_next  = step_index_reg;
        index_valid_next = index_valid_reg;
        hold_start_next  = hold_start_reg;
        heater_next      = heater_reg;

        case (func)
            FN_START:
            begin
                if (phase_reg == PH_OFF)
                begin
                    phase_next = PH_STARTING;
                end
            end
            FN_STOP:
            begin
                phase_next  = PH_STOPPING;
                heater_next = 1'b0;
            end
            FN_SAMPLE:
            begin
                case (phase_reg)
                    PH_STARTING:
                    begin
                        step_index_next  = '0;
                        index_valid_next = 1'b1;
                        phase_next = (active_count == '0) ? PH_STOPPING : PH_PREPARING;
                    end
                    PH_STOPPING:
                    begin
                        phase_next       = PH_OFF;
                        step_index_next  = '0;
                        index_valid_next = 1'b0;
                        heater_next      = 1'b0;
                    end
                    PH_PREPARING, PH_HOLDING:
                    begin
                        if (step_index_reg >= active_count)
                        begin
                            // Count was cut below the running step
                            phase_next  = PH_STOPPING;
                            heater_next = 1'b0;
                        end
                        else if (phase_reg == PH_PREPARING)
                        begin
                            if (sample_temp >= target)
                            begin
                                phase_next      = PH_HOLDING;
                                hold_start_next = timestamp_ms;
                                heater_next     = 1'b0;
                            end
                            else
                            begin
                                heater_next = 1'b1;
                            end
                        end
                        else if (elapsed > hold_ms)
                        begin
                            // Advance; heater left as is on this sample
                            step_index_next = step_inc;
                            phase_next = (step_inc < active_count) ? PH_PREPARING
                                                                   : PH_STOPPING;
                        end
                        else if (temp_ext <= band_low)
                        begin
                            heater_next = 1'b1;
                        end
                        else if (sample_temp >= target)
                        begin
                            heater_next = 1'b0;
                        end
                    end
                    default:
                    begin
                        phase_next = phase_reg;
                    end
                endcase
            end
            default:
            begin
                phase_next = phase_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_OFF;
            step_index_reg  <= '0;
            index_valid_reg <= 1'b0;
            hold_start_reg  <= '0;
            heater_reg      <= 1'b0;
        end
        else if (s_fire)
        begin
            phase_reg       <= phase_next;
            step_index_reg  <= step_index_next;
            index_valid_reg <= index_valid_next;
            hold_start_reg  <= hold_start_next;
            heater_reg      <= heater_next;
        end
    end

    // Status word register: load on accept, drop once taken
    assign cur_step_out = index_valid_next ? step_index_next : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (s_fire)
        begin
            m_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            m_data_reg <= {{(OUT_DATA_W - OUT_USED_W){1'b0}},
                           phase_next,
                           cur_step_out,
                           index_valid_next,
                           (phase_next != PH_OFF),
                           heater_next};
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    // Checks
    a_stop_forces_off_heater: assert property (@(posedge clk) disable iff (!rst_n)
        s_fire && func == FN_STOP |=> phase_reg == PH_STOPPING && !heater_reg)
        else $error("stop did not force stopping with heater off");

    a_off_is_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_OFF |-> !heater_reg && !index_valid_reg)
        else $error("heater or step index live while off");

    a_state_holds_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !s_fire |=> $stable(phase_reg) && $stable(heater_reg) && $stable(step_index_reg))
        else $error("controller state moved without an accepted word");

    a_step_field_clear: assert property (@(posedge clk) disable iff (!rst_n)
        m_valid_reg && !m_data_reg[2] |-> m_data_reg[5:3] == '0)
        else $error("current step reported without valid index");

    a_accept_loads_output: assert property (@(posedge clk) disable iff (!rst_n)
        s_fire |=> m_valid_reg)
        else $error("accepted word produced no status word");

endmodule
